// ----- hw/rtl/gcl_pkg.sv -----
// Shared constants, types and the command and status structs of the gcd/lcm unit.
package gcl_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int CNT_W = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;
  localparam int PROD_W = 2 * OPERAND_WIDTH;

  localparam logic FUNC_GCD = 1'b0;
  localparam logic FUNC_LCM = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIV,
    S_MUL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic set_gcd;
    logic set_zero;
    logic div_init;
    logic div_step;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sel;
    logic zero;
    logic gcd_done;
    logic div_last;
  } status_t;

endpackage

// ----- hw/rtl/gcd_lcm_unit_top.sv -----
// Top level of the gcd/lcm unit: controller plus datapath.
// The input channel (in_valid, in_stall, func, operand_a, operand_b) takes one
// request when in_valid is high and in_stall is low. The output channel
// (out_valid, out_stall, result) delivers one result per request, the gcd
// when func is 0 and the lcm when func is 1.
// The binary gcd loop sets most of the latency. A gcd is taken into the
// operand registers, reduced by the binary gcd loop, written to the result
// register and then moved into the output register. An lcm adds a restoring
// division of operand_a by the gcd and the multiplication of the quotient by
// operand_b before the result reaches the output register.
// One request is worked on at a time; the next one is taken the cycle after
// the previous result has moved into the output register, even while that
// result still waits to be taken.
// A zero operand gives gcd(0, b) = b, gcd(a, 0) = a and an lcm of 0.
// Reset empties the output register and returns the controller to idle.
// While out_valid and out_stall are both high the result holds; a finished
// computation then waits in the controller and in_stall stays high.
module gcd_lcm_unit_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [gcl_pkg::OPERAND_WIDTH-1:0] operand_a,
  input  logic [gcl_pkg::OPERAND_WIDTH-1:0] operand_b,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       result
);
  import gcl_pkg::*;

  cmd_t    cmd;
  status_t status;

  gcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gcl_datapath u_datapath (
    .clk       (clk),
    .func      (func),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

// ----- hw/rtl/gcl_datapath.sv -----
// Datapath of the gcd/lcm unit: binary gcd, restoring divider and multiplier.
module gcl_datapath (
  input  logic                                clk,
  input  logic                                func,
  input  logic [gcl_pkg::OPERAND_WIDTH-1:0]   operand_a,
  input  logic [gcl_pkg::OPERAND_WIDTH-1:0]   operand_b,
  input  gcl_pkg::cmd_t                       cmd,
  output gcl_pkg::status_t                    status,
  output logic [31:0]                         result
);
  import gcl_pkg::*;

  logic                     sel;
  logic [OPERAND_WIDTH-1:0] a_reg;
  logic [OPERAND_WIDTH-1:0] b_reg;
  logic [OPERAND_WIDTH-1:0] x;
  logic [OPERAND_WIDTH-1:0] y;
  logic [CNT_W-1:0]         k;
  logic [OPERAND_WIDTH-1:0] g;
  logic [OPERAND_WIDTH-1:0] quo;
  logic [OPERAND_WIDTH-1:0] rem;
  logic [CNT_W-1:0]         cnt;
  logic [31:0]              res;

  logic [OPERAND_WIDTH-1:0] gcd_val;
  logic [OPERAND_WIDTH:0]   trial;
  logic [OPERAND_WIDTH:0]   trial_diff;
  logic [PROD_W-1:0]        prod;
  logic [63:0]              prod_ext;

  assign gcd_val    = OPERAND_WIDTH'(x << k);
  assign trial      = {rem, quo[OPERAND_WIDTH-1]};
  assign trial_diff = trial - {1'b0, g};
  assign prod       = PROD_W'(quo) * PROD_W'(b_reg);
  assign prod_ext   = 64'(prod);

  assign status.sel      = sel;
  assign status.zero     = (a_reg == '0) || (b_reg == '0);
  assign status.gcd_done = status.zero || (x == y);
  assign status.div_last = (cnt == CNT_W'(OPERAND_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sel   <= func;
      a_reg <= operand_a;
      b_reg <= operand_b;
      x     <= operand_a;
      y     <= operand_b;
      k     <= '0;
    end else if (cmd.gcd_step) begin
      if (!x[0] && !y[0]) begin
        x <= x >> 1;
        y <= y >> 1;
        k <= k + 1'b1;
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x > y) begin
        x <= (x - y) >> 1;
      end else begin
        y <= (y - x) >> 1;
      end
    end

    if (cmd.set_gcd) begin
      res <= status.zero ? 32'(a_reg | b_reg) : 32'(gcd_val);
    end else if (cmd.set_zero) begin
      res <= '0;
    end else if (cmd.mul) begin
      res <= (|prod_ext[63:32]) ? 32'hFFFF_FFFF : prod_ext[31:0];
    end

    if (cmd.div_init) begin
      g   <= gcd_val;
      quo <= a_reg;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial_diff[OPERAND_WIDTH]) begin
        rem <= trial_diff[OPERAND_WIDTH-1:0];
        quo <= {quo[OPERAND_WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial[OPERAND_WIDTH-1:0];
        quo <= {quo[OPERAND_WIDTH-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end

    if (cmd.out_load) begin
      result <= res;
    end
  end

endmodule

// ----- hw/rtl/gcl_ctrl.sv -----
// Controller of the gcd/lcm unit: sequences the datapath and owns the handshakes.
module gcl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  gcl_pkg::status_t  status,
  output gcl_pkg::cmd_t     cmd
);
  import gcl_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (!status.gcd_done) begin
          cmd.gcd_step = 1'b1;
        end else if (status.sel == FUNC_GCD) begin
          cmd.set_gcd = 1'b1;
          state_next  = S_FIN;
        end else if (status.zero) begin
          cmd.set_zero = 1'b1;
          state_next   = S_FIN;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/gcl_checker.sv -----
// Port-level assertions of the gcd/lcm unit and their binding to the top level.
module gcl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Output request dropped while stalled.");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result))
    else $error("Result changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input taken again right after a request.");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared without a request in progress.");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Block not idle and empty after reset.");

endmodule

bind gcd_lcm_unit_top gcl_checker u_gcl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .result    (result)
);

// ----- bench/tb_top.sv -----
// Self-checking testbench of the gcd/lcm unit with randomly idling driver and monitor.
`timescale 1ns / 1ps

module tb_top;
  import gcl_pkg::*;

  localparam int W = OPERAND_WIDTH;
  localparam int OP_MAX = (1 << W) - 1;

  typedef struct packed {
    logic         func;
    logic [W-1:0] a;
    logic [W-1:0] b;
  } request_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic         func = FUNC_GCD;
  logic [W-1:0] operand_a = '0;
  logic [W-1:0] operand_b = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [31:0]  result;

  request_t    pending_requests[$];
  logic [31:0] due_results[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;

  gcd_lcm_unit_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] gcd_or_lcm(logic f, logic [W-1:0] a, logic [W-1:0] b);
    longint unsigned x;
    longint unsigned y;
    longint unsigned r;
    longint unsigned l;
    x = a;
    y = b;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    if (f == FUNC_GCD) return x[31:0];
    if (a == 0 || b == 0) return 32'd0;
    l = (longint'(a) / x) * longint'(b);
    if (l > 64'hFFFF_FFFF) l = 64'hFFFF_FFFF;
    return l[31:0];
  endfunction

  task automatic add_request(logic f, int a, int b);
    request_t req;
    req.func = f;
    req.a = a[W-1:0];
    req.b = b[W-1:0];
    pending_requests.insert(pending_requests.size(), req);
  endtask

  task automatic add_random_requests(int count);
    int a;
    int b;
    int g;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: begin
          a = $urandom_range(1, OP_MAX);
          b = $urandom_range(1, OP_MAX);
        end
        1: begin
          g = $urandom_range(1, 255);
          a = g * $urandom_range(1, OP_MAX / g);
          b = g * $urandom_range(1, OP_MAX / g);
        end
        2: begin
          a = $urandom_range(1, 255);
          b = $urandom_range(1, 255);
        end
        default: begin
          a = $urandom_range(1, 255) << $urandom_range(0, W - 8);
          b = $urandom_range(1, 255) << $urandom_range(0, W - 8);
        end
      endcase
      add_request($urandom_range(1) ? FUNC_LCM : FUNC_GCD, a, b);
    end
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin : driver
    request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        due_results.insert(due_results.size(), gcd_or_lcm(func, operand_a, operand_b));
      end
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_requests.pop_front();
        func <= req.func;
        operand_a <= req.a;
        operand_b <= req.b;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    logic [31:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d", result);
        end else begin
          want = due_results.pop_front();
          if (result !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("result: expected %0d, got %0d", want, result);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int f = 0; f < 2; f++) begin
      add_request(f[0], 1, 1);
      add_request(f[0], 1, OP_MAX);
      add_request(f[0], OP_MAX, 1);
      add_request(f[0], OP_MAX, OP_MAX);
      add_request(f[0], OP_MAX, OP_MAX - 1);
      add_request(f[0], 65521, 65519);
      add_request(f[0], 32768, OP_MAX);
      add_request(f[0], 32768, 16384);
      add_request(f[0], 65498, 32749);
      add_request(f[0], 12, 18);
      add_request(f[0], 46341, 46340);
    end
    wait_until_drained();

    add_random_requests(320);
    wait_until_drained();

    send_idle_pct = 62;
    add_random_requests(310);
    wait_until_drained();

    send_idle_pct = 0;
    recv_stall_pct = 62;
    add_random_requests(310);
    wait_until_drained();

    send_idle_pct = 13;
    recv_stall_pct = 13;
    add_random_requests(310);
    wait_until_drained();

    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
